/* sv/imu_pkg.sv */
// ----------------------------------------------------------------------------
// IMU measurement package
// Shared constants, types and fixed-point helpers for the innovation and
// Jacobian unit.
// ----------------------------------------------------------------------------
package imu_pkg;

    localparam int          CORDIC_STEPS_DEF = 24;
    localparam logic [30:0] GRAVITY_RESET    = 31'd642690;
    localparam logic [31:0] ONE_Q16          = 32'sd65536;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

    typedef enum logic [0:0] {
        MODE_ACCEL = 1'b0,
        MODE_GYRO  = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] roll;
        logic [31:0] pitch;
        logic [31:0] roll_rate;
        logic [31:0] pitch_rate;
        logic [31:0] yaw_rate;
        logic [31:0] meas_x;
        logic [31:0] meas_y;
        logic [31:0] meas_z;
        logic [30:0] var_x;
        logic [30:0] var_y;
        logic [30:0] var_z;
        logic [30:0] gravity;
    } t_item;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] s0;
        logic [31:0] c0;
        logic [31:0] s1;
        logic [31:0] c1;
        logic [31:0] roll_rate;
        logic [31:0] pitch_rate;
        logic [31:0] yaw_rate;
        logic [31:0] meas_x;
        logic [31:0] meas_y;
        logic [31:0] meas_z;
        logic [30:0] var_x;
        logic [30:0] var_y;
        logic [30:0] var_z;
        logic [30:0] gravity;
    } t_trig;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] innovation;
        logic [31:0] h_roll;
        logic [31:0] h_pitch;
        logic [31:0] h_roll_rate;
        logic [31:0] h_pitch_rate;
        logic [31:0] h_yaw_rate;
        logic [30:0] noise_variance;
        logic        last;
    } t_row;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) r = 32'h7fffffff;
        else if (v < -64'sd2147483648) r = 32'h80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        p = (p + 64'sd32768) >>> 16;
        return sat32(p);
    endfunction

    function automatic logic [31:0] qadd(input logic [31:0] a, input logic [31:0] b);
        return sat32(64'($signed(a)) + 64'($signed(b)));
    endfunction

    function automatic logic [31:0] qsub(input logic [31:0] a, input logic [31:0] b);
        return sat32(64'($signed(a)) - 64'($signed(b)));
    endfunction

    function automatic logic [31:0] qneg(input logic [31:0] a);
        return sat32(-64'($signed(a)));
    endfunction

    function automatic logic signed [35:0] atan_q30(input int i);
        logic signed [35:0] r;
        case (i)
            0: r = 36'sd843314857;
            1: r = 36'sd497837829;
            2: r = 36'sd263043837;
            3: r = 36'sd133525159;
            4: r = 36'sd67021687;
            5: r = 36'sd33543516;
            6: r = 36'sd16775851;
            7: r = 36'sd8388437;
            8: r = 36'sd4194283;
            9: r = 36'sd2097149;
            default: r = (i <= 30) ? (36'sd1 <<< (30 - i)) : 36'sd0;
        endcase
        return r;
    endfunction

endpackage

/* sv/imu_cordic.sv */
// ----------------------------------------------------------------------------
// IMU CORDIC pipeline
// Front part: range reduction then one rotation stage per step for roll and
// pitch at once, carrying the item alongside.
// ----------------------------------------------------------------------------
module imu_cordic import imu_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_trig o_trig
);

    localparam int NS = CORDIC_STEPS + 3;
    // floor(2^32 / (2*pi in Q16.16)), estimate of turns within one
    localparam logic [15:0] RECIP_2PI = 16'd10430;

    logic               r_v    [NS];
    t_item              r_it   [NS];
    logic signed [35:0] r_x    [NS][2];
    logic signed [35:0] r_y    [NS][2];
    logic signed [35:0] r_z    [NS][2];
    logic               r_flip [NS][2];
    logic signed [15:0] r_q    [2];
    logic signed [35:0] r_r    [2];

    logic signed [31:0] n_ang    [2];
    logic signed [47:0] n_prod   [2];
    logic signed [15:0] n_q      [2];
    logic signed [47:0] n_scaled [2];
    logic signed [35:0] n_mod    [2];
    logic signed [35:0] n_red    [2];
    logic signed [35:0] n_fold   [2];
    logic               n_flip   [2];

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_ang[a]  = (a == 0) ? $signed(i_item.roll) : $signed(i_item.pitch);
            n_prod[a] = 48'(n_ang[a]) * 48'($signed(RECIP_2PI));
            n_q[a]    = 16'(n_prod[a] >>> 32);
            n_scaled[a] = (a == 0) ? 48'($signed(r_it[0].roll)) <<< 14
                                   : 48'($signed(r_it[0].pitch)) <<< 14;
            n_mod[a] = 36'(n_scaled[a] - 48'(r_q[a]) * 48'(TWO_PI_Q30));
            n_red[a] = (r_r[a] < 0) ? r_r[a] + TWO_PI_Q30 : r_r[a];
            if (n_red[a] > PI_Q30) n_red[a] = n_red[a] - TWO_PI_Q30;
            n_flip[a] = 1'b0;
            n_fold[a] = n_red[a];
            if (n_red[a] > HALF_PI_Q30) begin
                n_fold[a] = PI_Q30 - n_red[a];
                n_flip[a] = 1'b1;
            end else if (n_red[a] < -HALF_PI_Q30) begin
                n_fold[a] = -PI_Q30 - n_red[a];
                n_flip[a] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0] <= i_item;
            for (int a = 0; a < 2; a++) r_q[a] <= n_q[a];
            r_it[1] <= r_it[0];
            for (int a = 0; a < 2; a++) r_r[a] <= n_mod[a];
            r_it[2] <= r_it[1];
            for (int a = 0; a < 2; a++) begin
                r_x[2][a]    <= GAIN_Q30;
                r_y[2][a]    <= '0;
                r_z[2][a]    <= n_fold[a];
                r_flip[2][a] <= n_flip[a];
            end
            for (int k = 3; k < NS; k++) begin
                r_it[k] <= r_it[k-1];
                for (int a = 0; a < 2; a++) begin
                    r_flip[k][a] <= r_flip[k-1][a];
                    if (r_z[k-1][a] >= 0) begin
                        r_x[k][a] <= r_x[k-1][a] - (r_y[k-1][a] >>> (k-3));
                        r_y[k][a] <= r_y[k-1][a] + (r_x[k-1][a] >>> (k-3));
                        r_z[k][a] <= r_z[k-1][a] - atan_q30(k-3);
                    end else begin
                        r_x[k][a] <= r_x[k-1][a] + (r_y[k-1][a] >>> (k-3));
                        r_y[k][a] <= r_y[k-1][a] - (r_x[k-1][a] >>> (k-3));
                        r_z[k][a] <= r_z[k-1][a] + atan_q30(k-3);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] unit(input logic signed [35:0] v, input logic neg);
        logic signed [35:0] t;
        t = (v + 36'sd8192) >>> 14;
        if (t > 36'sd65536) t = 36'sd65536;
        if (t < -36'sd65536) t = -36'sd65536;
        if (neg) t = -t;
        return t[31:0];
    endfunction

    t_item w_it;
    assign w_it = r_it[NS-1];
    assign o_valid = r_v[NS-1];

    always_comb begin
        o_trig.mode       = w_it.mode;
        o_trig.s0         = unit(r_y[NS-1][0], 1'b0);
        o_trig.c0         = unit(r_x[NS-1][0], r_flip[NS-1][0]);
        o_trig.s1         = unit(r_y[NS-1][1], 1'b0);
        o_trig.c1         = unit(r_x[NS-1][1], r_flip[NS-1][1]);
        o_trig.roll_rate  = w_it.roll_rate;
        o_trig.pitch_rate = w_it.pitch_rate;
        o_trig.yaw_rate   = w_it.yaw_rate;
        o_trig.meas_x     = w_it.meas_x;
        o_trig.meas_y     = w_it.meas_y;
        o_trig.meas_z     = w_it.meas_z;
        o_trig.var_x      = w_it.var_x;
        o_trig.var_y      = w_it.var_y;
        o_trig.var_z      = w_it.var_z;
        o_trig.gravity    = w_it.gravity;
    end

endmodule

/* sv/imu_queue.sv */
// ----------------------------------------------------------------------------
// IMU decoupling queue
// Short queue between the CORDIC front part and the row back part.
// ----------------------------------------------------------------------------
module imu_queue import imu_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_trig i_data,
    input  logic  i_pop,
    output logic  o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output t_trig o_data
);

    localparam int AW = $clog2(DEPTH);

    t_trig                  r_mem [DEPTH];
    logic [AW-1:0]          r_wp, r_rp;
    logic [$clog2(DEPTH+1)-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

endmodule

/* sv/imu_rows.sv */
// ----------------------------------------------------------------------------
// IMU row generator
// Back part: products in one stage, then one row per cycle, while i_stall is low,
// into an output register.
// ----------------------------------------------------------------------------
module imu_rows import imu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_trig i_trig,
    output logic  o_take,
    output logic  o_valid,
    input  logic  i_stall,
    output t_row  o_row
);

    // stage A: pair products
    logic        r_av;
    t_trig       r_a;
    logic [31:0] r_s0c1, r_c0c1, r_s0s1, r_c0s1;
    // stage B: full rows
    logic        r_bv;
    t_row        r_b [3];
    logic [1:0]  r_k;
    logic        r_ov;
    t_row        r_o;

    logic w_out_free, w_b_adv, w_b_free, w_a_free;

    assign w_out_free = !r_ov || !i_stall;
    assign w_b_adv    = r_bv && w_out_free;
    assign w_b_free   = !r_bv || (w_b_adv && r_k == 2'd2);
    assign w_a_free   = !r_av || w_b_free;
    assign o_take     = i_valid && w_a_free;

    logic [31:0] g, t_s1g, t_s0c1g, t_c0c1g, t_c1g, t_s0s1g, t_c0s1g;
    logic [31:0] t_s1y, t_c0p, t_s0c1y, t_s0p, t_c0c1y, t_c1y, t_s0s1y, t_c0s1y;
    t_row n_b [3];

    always_comb begin
        g       = {1'b0, r_a.gravity};
        t_s1g   = qmul(r_a.s1, g);
        t_s0c1g = qmul(r_s0c1, g);
        t_c0c1g = qmul(r_c0c1, g);
        t_c1g   = qmul(r_a.c1, g);
        t_s0s1g = qmul(r_s0s1, g);
        t_c0s1g = qmul(r_c0s1, g);
        t_s1y   = qmul(r_a.s1, r_a.yaw_rate);
        t_c0p   = qmul(r_a.c0, r_a.pitch_rate);
        t_s0c1y = qmul(r_s0c1, r_a.yaw_rate);
        t_s0p   = qmul(r_a.s0, r_a.pitch_rate);
        t_c0c1y = qmul(r_c0c1, r_a.yaw_rate);
        t_c1y   = qmul(r_a.c1, r_a.yaw_rate);
        t_s0s1y = qmul(r_s0s1, r_a.yaw_rate);
        t_c0s1y = qmul(r_c0s1, r_a.yaw_rate);
        for (int k = 0; k < 3; k++) begin
            n_b[k] = '0;
            n_b[k].row  = 2'(k);
            n_b[k].last = (k == 2);
        end
        n_b[0].noise_variance = r_a.var_x;
        n_b[1].noise_variance = r_a.var_y;
        n_b[2].noise_variance = r_a.var_z;
        case (r_a.mode)
            MODE_ACCEL: begin
                n_b[0].innovation = qadd(r_a.meas_x, t_s1g);
                n_b[1].innovation = qsub(r_a.meas_y, t_s0c1g);
                n_b[2].innovation = qsub(r_a.meas_z, t_c0c1g);
                n_b[0].h_pitch    = qneg(t_c1g);
                n_b[1].h_roll     = t_c0c1g;
                n_b[1].h_pitch    = qneg(t_s0s1g);
                n_b[2].h_roll     = qneg(t_s0c1g);
                n_b[2].h_pitch    = qneg(t_c0s1g);
            end
            MODE_GYRO: begin
                n_b[0].innovation = qsub(r_a.meas_x, qadd(r_a.roll_rate, t_s1y));
                n_b[1].innovation = qsub(r_a.meas_y, qadd(t_c0p, t_s0c1y));
                n_b[2].innovation = qsub(r_a.meas_z, qadd(qneg(t_s0p), t_c0c1y));
                n_b[0].h_pitch      = t_c1y;
                n_b[0].h_roll_rate  = ONE_Q16;
                n_b[0].h_yaw_rate   = r_a.s1;
                n_b[1].h_roll       = qadd(qneg(t_s0p), t_c0c1y);
                n_b[1].h_pitch      = qneg(t_s0s1y);
                n_b[1].h_pitch_rate = r_a.c0;
                n_b[1].h_yaw_rate   = r_s0c1;
                n_b[2].h_roll       = qsub(qneg(t_c0p), t_s0c1y);
                n_b[2].h_pitch      = qneg(t_c0s1y);
                n_b[2].h_pitch_rate = qneg(r_a.s0);
                n_b[2].h_yaw_rate   = r_c0c1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0; r_bv <= 1'b0; r_ov <= 1'b0; r_k <= '0;
        end else begin
            if (w_a_free) r_av <= o_take;
            if (w_b_free) r_bv <= r_av;
            if (w_b_adv) r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            if (w_out_free) r_ov <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_free && o_take) begin
            r_a    <= i_trig;
            r_s0c1 <= qmul(i_trig.s0, i_trig.c1);
            r_c0c1 <= qmul(i_trig.c0, i_trig.c1);
            r_s0s1 <= qmul(i_trig.s0, i_trig.s1);
            r_c0s1 <= qmul(i_trig.c0, i_trig.s1);
        end
        if (w_b_free && r_av) r_b <= n_b;
        if (w_b_adv) r_o <= r_b[r_k];
    end

    assign o_valid = r_ov;
    assign o_row   = r_o;

    a_last_on_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o.last == (r_o.row == 2'd2))) else $error("last flag mismatch");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_o.row != 2'd3)) else $error("row out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_o))) else $error("stalled row changed");

endmodule

/* sv/imu_innovation_and_jacobian_unit.sv */
// ----------------------------------------------------------------------------
// IMU innovation and Jacobian unit
// Throughput: one row per cycle while i_stall is low, three rows per item, set by the row stage.
// The CORDIC pipeline takes a word every cycle while o_stall is low; the queue absorbs bursts.
// Reset: synchronous active low; clears control, gravity to 9.80665.
// ----------------------------------------------------------------------------
module imu_innovation_and_jacobian_unit import imu_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [31:0] i_roll,
    input  logic [31:0] i_pitch,
    input  logic [31:0] i_roll_rate,
    input  logic [31:0] i_pitch_rate,
    input  logic [31:0] i_yaw_rate,
    input  logic [31:0] i_meas_x,
    input  logic [31:0] i_meas_y,
    input  logic [31:0] i_meas_z,
    input  logic [30:0] i_var_x,
    input  logic [30:0] i_var_y,
    input  logic [30:0] i_var_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_row,
    output logic [31:0] o_innovation,
    output logic [31:0] o_h_roll,
    output logic [31:0] o_h_pitch,
    output logic [31:0] o_h_roll_rate,
    output logic [31:0] o_h_pitch_rate,
    output logic [31:0] o_h_yaw_rate,
    output logic [30:0] o_noise_variance,
    output logic        o_last
);

    // queue depth is CORDIC_STEPS + 4, capped at 32; the credit check keeps it from overflow
    localparam int QD = (CORDIC_STEPS + 4 > 32) ? 32 : CORDIC_STEPS + 4;
    localparam int CW = $clog2(QD+1);

    logic [30:0] r_gravity;
    t_item       w_item;
    logic        w_cv, w_take, w_empty, w_acc;
    t_trig       w_ct, w_qd;
    t_row        w_row;
    logic [CW-1:0] w_cnt;
    logic [CW-1:0] r_fly;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_gravity <= GRAVITY_RESET;
        else if (i_cfg_valid) r_gravity <= i_cfg_data;
    end

    always_comb begin
        w_item.mode       = t_mode'(i_mode);
        w_item.roll       = i_roll;
        w_item.pitch      = i_pitch;
        w_item.roll_rate  = i_roll_rate;
        w_item.pitch_rate = i_pitch_rate;
        w_item.yaw_rate   = i_yaw_rate;
        w_item.meas_x     = i_meas_x;
        w_item.meas_y     = i_meas_y;
        w_item.meas_z     = i_meas_z;
        w_item.var_x      = i_var_x;
        w_item.var_y      = i_var_y;
        w_item.var_z      = i_var_z;
        w_item.gravity    = r_gravity;
    end

    // credit: items in pipe plus queue must not exceed queue depth
    assign o_stall = (CW'(r_fly) + w_cnt) >= CW'(QD);
    assign w_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fly <= '0;
        else r_fly <= r_fly + (w_acc ? 1'b1 : 1'b0) - (w_cv ? 1'b1 : 1'b0);
    end

    imu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(1'b1),
        .i_valid(w_acc), .i_item(w_item), .o_valid(w_cv), .o_trig(w_ct)
    );

    imu_queue #(.DEPTH(QD)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_cv), .i_data(w_ct),
        .i_pop(w_take), .o_empty(w_empty), .o_count(w_cnt), .o_data(w_qd)
    );

    imu_rows u_rows (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(!w_empty), .i_trig(w_qd),
        .o_take(w_take), .o_valid(o_valid), .i_stall(i_stall), .o_row(w_row)
    );

    assign o_row            = w_row.row;
    assign o_innovation     = w_row.innovation;
    assign o_h_roll         = w_row.h_roll;
    assign o_h_pitch        = w_row.h_pitch;
    assign o_h_roll_rate    = w_row.h_roll_rate;
    assign o_h_pitch_rate   = w_row.h_pitch_rate;
    assign o_h_yaw_rate     = w_row.h_yaw_rate;
    assign o_noise_variance = w_row.noise_variance;
    assign o_last           = w_row.last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_fly) + w_cnt) <= CW'(QD)) else $error("queue credit overrun");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> !w_empty) else $error("pop from empty queue");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cv |-> (w_cnt < CW'(QD) || w_take)) else $error("push into full queue");

endmodule

/* tb/imu_checker.sv */
// ----------------------------------------------------------------------------
// IMU innovation and Jacobian checker
// Watches the input, output and gravity channels, predicts the three rows of
// every accepted word in fixed point and compares each returned row with the
// oldest prediction. Hands the failure and pending row counts to the top.
// ----------------------------------------------------------------------------
module imu_checker import imu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [30:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_mode,
    input  logic [31:0] i_roll,
    input  logic [31:0] i_pitch,
    input  logic [31:0] i_roll_rate,
    input  logic [31:0] i_pitch_rate,
    input  logic [31:0] i_yaw_rate,
    input  logic [31:0] i_meas_x,
    input  logic [31:0] i_meas_y,
    input  logic [31:0] i_meas_z,
    input  logic [30:0] i_var_x,
    input  logic [30:0] i_var_y,
    input  logic [30:0] i_var_z,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_row        i_row,
    output int          o_fail_count,
    output int          o_pending
);

    localparam longint ONE = 65536;

    longint arctan_tab [10] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149
    };

    logic [30:0] gravity_q;
    t_row        rows_due [$];

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return clip32((a * b + 32768) >>> 16);
    endfunction

    function automatic longint unit_clip(input longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    task automatic angle_trig(input logic [31:0] ang, output longint s, output longint c);
        longint r, x, y, z, nx, ny, at;
        bit     flip;
        flip = 0;
        r = (longint'($signed(ang)) * 16384) % longint'(TWO_PI_Q30);
        if (r < 0) r += longint'(TWO_PI_Q30);
        if (r > longint'(PI_Q30)) r -= longint'(TWO_PI_Q30);
        if (r > longint'(HALF_PI_Q30)) begin
            r = longint'(PI_Q30) - r;
            flip = 1;
        end else if (r < -longint'(HALF_PI_Q30)) begin
            r = -longint'(PI_Q30) - r;
            flip = 1;
        end
        x = longint'(GAIN_Q30);
        y = 0;
        z = r;
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
            if (i < 10) at = arctan_tab[i];
            else if (i <= 30) at = longint'(1) << (30 - i);
            else at = 0;
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= at;
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += at;
            end
            x = nx;
            y = ny;
        end
        c = unit_clip((x + 8192) >>> 14);
        s = unit_clip((y + 8192) >>> 14);
        if (flip) c = -c;
    endtask

    task automatic predict_rows();
        longint s0, c0, s1, c1, s0c1, c0c1, s0s1, c0s1, g, rr, pr, yr;
        longint m [3];
        longint v [3][6];
        logic [30:0] nv [3];
        t_row r;
        angle_trig(i_roll, s0, c0);
        angle_trig(i_pitch, s1, c1);
        s0c1 = fx_mul(s0, c1);
        c0c1 = fx_mul(c0, c1);
        s0s1 = fx_mul(s0, s1);
        c0s1 = fx_mul(c0, s1);
        g  = longint'(gravity_q);
        rr = longint'($signed(i_roll_rate));
        pr = longint'($signed(i_pitch_rate));
        yr = longint'($signed(i_yaw_rate));
        m[0] = longint'($signed(i_meas_x));
        m[1] = longint'($signed(i_meas_y));
        m[2] = longint'($signed(i_meas_z));
        nv[0] = i_var_x;
        nv[1] = i_var_y;
        nv[2] = i_var_z;
        foreach (v[k, j]) v[k][j] = 0;
        if (t_mode'(i_mode) == MODE_ACCEL) begin
            v[0][0] = clip32(m[0] + fx_mul(s1, g));
            v[1][0] = clip32(m[1] - fx_mul(s0c1, g));
            v[2][0] = clip32(m[2] - fx_mul(c0c1, g));
            v[0][2] = clip32(-fx_mul(c1, g));
            v[1][1] = fx_mul(c0c1, g);
            v[1][2] = clip32(-fx_mul(s0s1, g));
            v[2][1] = clip32(-fx_mul(s0c1, g));
            v[2][2] = clip32(-fx_mul(c0s1, g));
        end else begin
            v[0][0] = clip32(m[0] - clip32(rr + fx_mul(s1, yr)));
            v[1][0] = clip32(m[1] - clip32(fx_mul(c0, pr) + fx_mul(s0c1, yr)));
            v[2][0] = clip32(m[2] - clip32(clip32(-fx_mul(s0, pr)) + fx_mul(c0c1, yr)));
            v[0][2] = fx_mul(c1, yr);
            v[0][3] = ONE;
            v[0][5] = s1;
            v[1][1] = clip32(clip32(-fx_mul(s0, pr)) + fx_mul(c0c1, yr));
            v[1][2] = clip32(-fx_mul(s0s1, yr));
            v[1][4] = c0;
            v[1][5] = s0c1;
            v[2][1] = clip32(clip32(-fx_mul(c0, pr)) - fx_mul(s0c1, yr));
            v[2][2] = clip32(-fx_mul(c0s1, yr));
            v[2][4] = clip32(-s0);
            v[2][5] = c0c1;
        end
        for (int k = 0; k < 3; k++) begin
            r.row            = 2'(k);
            r.innovation     = 32'(v[k][0]);
            r.h_roll         = 32'(v[k][1]);
            r.h_pitch        = 32'(v[k][2]);
            r.h_roll_rate    = 32'(v[k][3]);
            r.h_pitch_rate   = 32'(v[k][4]);
            r.h_yaw_rate     = 32'(v[k][5]);
            r.noise_variance = nv[k];
            r.last           = (k == 2);
            rows_due.push_back(r);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        gravity_q    = GRAVITY_RESET;
    end

    always @(posedge i_clk) begin
        t_row want;
        if (!i_rst_n) begin
            gravity_q = GRAVITY_RESET;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (rows_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected row word: %h", i_row);
                    o_fail_count++;
                end else begin
                    want = rows_due.pop_front();
                    if (i_row !== want) begin
                        if (o_fail_count < 10) begin
                            $display("row mismatch: exp row %0d inn %h hr %h hp %h hrr %h hpr %h hyr %h nv %h last %b",
                                     want.row, want.innovation, want.h_roll, want.h_pitch,
                                     want.h_roll_rate, want.h_pitch_rate, want.h_yaw_rate,
                                     want.noise_variance, want.last);
                            $display("              act row %0d inn %h hr %h hp %h hrr %h hpr %h hyr %h nv %h last %b",
                                     i_row.row, i_row.innovation, i_row.h_roll, i_row.h_pitch,
                                     i_row.h_roll_rate, i_row.h_pitch_rate, i_row.h_yaw_rate,
                                     i_row.noise_variance, i_row.last);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_rows();
            if (i_cfg_valid && i_cfg_ready) gravity_q = i_cfg_data;
        end
        o_pending = rows_due.size();
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// IMU innovation and Jacobian testbench
// Drives directed and random accelerometer and gyro words through the unit
// under several gravity settings and idling patterns; the checker predicts
// and compares every row, the top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import imu_pkg::*;

    localparam int SETTLE = CORDIC_STEPS_DEF + 16;
    localparam int WDOG_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    t_item       word;
    logic        o_valid;
    logic        i_stall;
    t_row        o_row;
    int          fail_count;
    int          pending;
    int          send_idle;
    int          recv_stall;
    int          quiet_cycles;

    imu_innovation_and_jacobian_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (word.mode),
        .i_roll           (word.roll),
        .i_pitch          (word.pitch),
        .i_roll_rate      (word.roll_rate),
        .i_pitch_rate     (word.pitch_rate),
        .i_yaw_rate       (word.yaw_rate),
        .i_meas_x         (word.meas_x),
        .i_meas_y         (word.meas_y),
        .i_meas_z         (word.meas_z),
        .i_var_x          (word.var_x),
        .i_var_y          (word.var_y),
        .i_var_z          (word.var_z),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_row            (o_row.row),
        .o_innovation     (o_row.innovation),
        .o_h_roll         (o_row.h_roll),
        .o_h_pitch        (o_row.h_pitch),
        .o_h_roll_rate    (o_row.h_roll_rate),
        .o_h_pitch_rate   (o_row.h_pitch_rate),
        .o_h_yaw_rate     (o_row.h_yaw_rate),
        .o_noise_variance (o_row.noise_variance),
        .o_last           (o_row.last)
    );

    imu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_mode       (word.mode),
        .i_roll       (word.roll),
        .i_pitch      (word.pitch),
        .i_roll_rate  (word.roll_rate),
        .i_pitch_rate (word.pitch_rate),
        .i_yaw_rate   (word.yaw_rate),
        .i_meas_x     (word.meas_x),
        .i_meas_y     (word.meas_y),
        .i_meas_z     (word.meas_z),
        .i_var_x      (word.var_x),
        .i_var_y      (word.var_y),
        .i_var_z      (word.var_z),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_row        (o_row),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) i_stall = ($urandom_range(99) < recv_stall);

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'($urandom_range(1, 4)) * 32'd102944;
            default: return 32'($urandom_range(0, 524288)) - 32'd262144;
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($urandom_range(0, 2097152)) - 32'd1048576;
    endfunction

    function automatic t_item random_word();
        t_item w;
        w.mode       = t_mode'($urandom_range(1));
        w.roll       = pick_angle();
        w.pitch      = pick_angle();
        w.roll_rate  = pick_value();
        w.pitch_rate = pick_value();
        w.yaw_rate   = pick_value();
        w.meas_x     = pick_value();
        w.meas_y     = pick_value();
        w.meas_z     = pick_value();
        w.var_x      = 31'($urandom);
        w.var_y      = 31'($urandom);
        w.var_z      = 31'($urandom);
        w.gravity    = '0;
        return w;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input t_item w);
        while ($urandom_range(99) < send_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        word    = w;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_gravity(input logic [30:0] g);
        drain();
        i_cfg_data  = g;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic directed_words();
        logic [31:0] angles [8] = '{32'd0, 32'd102944, -32'd102944, 32'd205887,
                                    -32'd205887, 32'h7fffffff, 32'h80000000, 32'd51472};
        t_item w;
        for (int i = 0; i < 16; i++) begin
            w = random_word();
            w.mode  = (i % 2) ? MODE_GYRO : MODE_ACCEL;
            w.roll  = angles[i % 8];
            w.pitch = angles[(i / 2) % 8];
            send_word(w);
        end
        foreach (angles[k]) begin
            if (k >= 4) break;
            w.mode       = (k % 2) ? MODE_GYRO : MODE_ACCEL;
            w.roll       = angles[k + 1];
            w.pitch      = angles[k];
            w.roll_rate  = (k < 2) ? 32'h7fffffff : 32'h80000000;
            w.pitch_rate = (k < 2) ? 32'h80000000 : 32'h7fffffff;
            w.yaw_rate   = (k % 2) ? 32'h7fffffff : 32'h80000000;
            w.meas_x     = (k % 2) ? 32'h80000000 : 32'h7fffffff;
            w.meas_y     = (k < 2) ? 32'h7fffffff : 32'h80000000;
            w.meas_z     = (k % 2) ? 32'h7fffffff : 32'h80000000;
            w.var_x      = (k % 2) ? 31'h7fffffff : 31'd0;
            w.var_y      = (k % 2) ? 31'd0 : 31'h7fffffff;
            w.var_z      = (k < 2) ? 31'h7fffffff : 31'd0;
            send_word(w);
        end
    endtask

    task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();
            send_word(random_word());
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        word         = '0;
        send_idle    = 0;
        recv_stall   = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_words();
        random_phase(60, 0, 0);
        write_gravity(31'd0);
        random_phase(50, 58, 0);
        write_gravity(31'h7fffffff);
        random_phase(60, 0, 58);
        write_gravity(31'($urandom));
        random_phase(80, 33, 33);
        write_gravity(31'd65536);
        random_phase(80, 0, 0);
        write_gravity(GRAVITY_RESET);
        random_phase(80, 33, 33);
        drain();

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
